// ===== design/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// csc_pkg
// Types and constants shared by the calendar second counter modules.
// ----------------------------------------------------------------------------
package csc_pkg;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [5:0] SEC_MAX     = 6'd59;
   localparam logic [5:0] MIN_MAX     = 6'd59;
   localparam logic [4:0] HOUR_MAX    = 5'd23;
   localparam logic [2:0] WEEKDAY_MAX = 3'd7;
   localparam logic [4:0] MONTHDAY_MAX = 5'd31;
   localparam logic [3:0] MONTH_MAX   = 4'd12;
   localparam logic [3:0] MONTH_FEB   = 4'd2;
   localparam logic [3:0] MONTH_APR   = 4'd4;
   localparam logic [3:0] MONTH_JUN   = 4'd6;
   localparam logic [3:0] MONTH_SEP   = 4'd9;
   localparam logic [3:0] MONTH_NOV   = 4'd11;
   localparam logic [3:0] PRINT_MINUTE_NIBBLE = 4'h8;
   localparam logic [5:0] REFRESH_SECOND = 6'd2;
   localparam logic [5:0] ALARM_SECOND   = 6'd3;

   typedef struct packed {
      logic       operation;
      logic [7:0] second_bcd;
      logic [7:0] minute_bcd;
      logic [7:0] hour_bcd;
      logic [7:0] weekday_bcd;
      logic [7:0] monthday_bcd;
      logic [7:0] month_bcd;
   } req_type;

   typedef struct packed {
      logic [5:0] second_now;
      logic [5:0] minute_now;
      logic [4:0] hour_now;
      logic [2:0] weekday_now;
      logic [4:0] monthday_now;
      logic [3:0] month_now;
      logic       led_level;
      logic       print_request;
      logic       refresh_request;
      logic       alarm_scan_request;
   } rsp_type;

   typedef struct packed {
      logic [5:0] sec;
      logic [5:0] min;
      logic [4:0] hour;
      logic [2:0] weekday;
      logic [4:0] monthday;
      logic [3:0] month;
   } time_type;

   typedef struct packed {
      logic print;
      logic refresh;
      logic alarm_scan;
   } flags_type;

   localparam time_type TIME_RESET = '{sec: 6'd0, min: 6'd0, hour: 5'd0,
                                       weekday: 3'd1, monthday: 5'd1, month: 4'd1};

   // BCD byte to binary: high nibble * 10 + low nibble, invalid digits included
   function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
      logic [7:0] hi;
      hi = {4'd0, b[7:4]};
      return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
   endfunction

   function automatic logic [4:0] month_length(input logic [3:0] m);
      logic [4:0] len;
      if (m == MONTH_FEB) begin
         len = 5'd29;
      end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
         len = 5'd30;
      end else begin
         len = 5'd31;
      end
      return len;
   endfunction

endpackage

// ===== design/calendar_second_counter.sv =====
// ----------------------------------------------------------------------------
// calendar_second_counter
// Time of day and calendar counter, advanced by one-second ticks or loaded
// from BCD bytes, with heartbeat LED and periodic request flags.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_stall  | req_data (req_type)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_data (rsp_type)
//  csr     | in        | csr_valid/csr_ready  | csr_data (refresh enable)
//
//  One request per cycle is sustained while rsp_stall is low; each request
//  passes through the input register and then the result register.
//  The time update is one pass of the carry chain between them.
//  Reset returns the time to 00:00:00, weekday 1, 1 January, LED off, and
//  refresh enabled. A stalled response holds the request in the input register.
// ----------------------------------------------------------------------------
module calendar_second_counter
   import csc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic      req_vld_ff, req_vld_in;
   req_type   req_ff, req_in;
   logic      rsp_vld_ff, rsp_vld_in;
   rsp_type   rsp_ff, rsp_in;
   time_type  time_ff, time_in;
   logic      led_ff, led_in;
   logic      refresh_ff, refresh_in;
   logic      advance;
   logic      req_take;
   time_type  time_nxt;
   logic      led_nxt;
   flags_type flags;

   csc_step u_step (
      .time_cur       (time_ff),
      .led_cur        (led_ff),
      .refresh_enable (refresh_ff),
      .req            (req_ff),
      .time_nxt       (time_nxt),
      .led_nxt        (led_nxt),
      .flags          (flags)
   );

   // process the held request whenever the result register is free or draining
   assign advance   = req_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = req_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      req_vld_in = req_take || (req_vld_ff && !advance);
      req_in     = req_take ? req_data : req_ff;
      rsp_vld_in = advance || (rsp_vld_ff && rsp_stall);
      rsp_in     = rsp_ff;
      time_in    = time_ff;
      led_in     = led_ff;
      refresh_in = (csr_valid && csr_ready) ? csr_data : refresh_ff;
      if (advance) begin
         time_in = time_nxt;
         led_in  = led_nxt;
         rsp_in  = '{second_now:         time_nxt.sec,
                     minute_now:         time_nxt.min,
                     hour_now:           time_nxt.hour,
                     weekday_now:        time_nxt.weekday,
                     monthday_now:       time_nxt.monthday,
                     month_now:          time_nxt.month,
                     led_level:          led_nxt,
                     print_request:      flags.print,
                     refresh_request:    flags.refresh,
                     alarm_scan_request: flags.alarm_scan};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         time_ff    <= TIME_RESET;
         led_ff     <= 1'b0;
         refresh_ff <= 1'b1;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         time_ff    <= time_in;
         led_ff     <= led_in;
         refresh_ff <= refresh_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/csc_step.sv =====
// ----------------------------------------------------------------------------
// csc_step
// Next time of day, calendar and request flags for one tick or load.
// ----------------------------------------------------------------------------
module csc_step
   import csc_pkg::*;
(
   input  time_type  time_cur,
   input  logic      led_cur,
   input  logic      refresh_enable,
   input  req_type   req,
   output time_type  time_nxt,
   output logic      led_nxt,
   output flags_type flags
);

   logic [7:0] sec_bin, min_bin, hour_bin, wd_bin, md_bin, mon_bin;
   time_type   loaded;
   time_type   ticked;
   logic       sec_wrap, min_wrap, hour_wrap, md_wrap;

   always_comb begin
      sec_bin  = bcd_to_bin(req.second_bcd);
      min_bin  = bcd_to_bin(req.minute_bcd);
      hour_bin = bcd_to_bin(req.hour_bcd);
      wd_bin   = bcd_to_bin(req.weekday_bcd);
      md_bin   = bcd_to_bin(req.monthday_bcd);
      mon_bin  = bcd_to_bin(req.month_bcd);

      loaded.sec  = (sec_bin > {2'd0, SEC_MAX}) ? SEC_MAX : sec_bin[5:0];
      loaded.min  = (min_bin > {2'd0, MIN_MAX}) ? MIN_MAX : min_bin[5:0];
      loaded.hour = (hour_bin > {3'd0, HOUR_MAX}) ? HOUR_MAX : hour_bin[4:0];
      priority if (wd_bin == 8'd0) begin
         loaded.weekday = 3'd1;
      end else if (wd_bin > {5'd0, WEEKDAY_MAX}) begin
         loaded.weekday = WEEKDAY_MAX;
      end else begin
         loaded.weekday = wd_bin[2:0];
      end
      priority if (md_bin == 8'd0) begin
         loaded.monthday = 5'd1;
      end else if (md_bin > {3'd0, MONTHDAY_MAX}) begin
         loaded.monthday = MONTHDAY_MAX;
      end else begin
         loaded.monthday = md_bin[4:0];
      end
      priority if (mon_bin == 8'd0) begin
         loaded.month = 4'd1;
      end else if (mon_bin > {4'd0, MONTH_MAX}) begin
         loaded.month = MONTH_MAX;
      end else begin
         loaded.month = mon_bin[3:0];
      end
   end

   // carry chain; stored values are in range but for a day loaded past the month end, and >= catches the wrap
   always_comb begin
      sec_wrap  = (time_cur.sec >= SEC_MAX);
      min_wrap  = sec_wrap && (time_cur.min >= MIN_MAX);
      hour_wrap = min_wrap && (time_cur.hour >= HOUR_MAX);
      // a day loaded past the month end also rolls the month
      md_wrap   = hour_wrap && (time_cur.monthday >= month_length(time_cur.month));

      ticked = time_cur;
      ticked.sec = sec_wrap ? 6'd0 : time_cur.sec + 6'd1;
      if (sec_wrap) begin
         ticked.min = (time_cur.min >= MIN_MAX) ? 6'd0 : time_cur.min + 6'd1;
      end
      if (min_wrap) begin
         ticked.hour = (time_cur.hour >= HOUR_MAX) ? 5'd0 : time_cur.hour + 5'd1;
      end
      if (hour_wrap) begin
         ticked.weekday  = (time_cur.weekday >= WEEKDAY_MAX) ? 3'd1 : time_cur.weekday + 3'd1;
         ticked.monthday = md_wrap ? 5'd1 : time_cur.monthday + 5'd1;
      end
      if (md_wrap) begin
         ticked.month = (time_cur.month >= MONTH_MAX) ? 4'd1 : time_cur.month + 4'd1;
      end
   end

   always_comb begin
      flags = '0;
      unique case (req.operation)
         OP_LOAD: begin
            time_nxt = loaded;
            led_nxt  = led_cur;
         end
         OP_TICK: begin
            time_nxt = ticked;
            led_nxt  = ~led_cur;
            flags.print      = (ticked.sec == 6'd0) && (ticked.min[3:0] == PRINT_MINUTE_NIBBLE);
            flags.refresh    = (ticked.sec == REFRESH_SECOND) && refresh_enable;
            flags.alarm_scan = (ticked.sec == ALARM_SECOND);
         end
         default: begin
            time_nxt = time_cur;
            led_nxt  = led_cur;
         end
      endcase
   end

endmodule
